[src/rgbhsv_pkg.sv]
// Shared types for the RGB to HSV pixel converter.
// Holds the sector code type; depends on nothing else.
`default_nettype none

package rgbhsv_pkg;

	// Which component is the largest; it picks the hue sector.
	typedef enum logic [1:0] {
		SECTOR_RED   = 2'd0,
		SECTOR_GREEN = 2'd1,
		SECTOR_BLUE  = 2'd2
	} sector_t;

endpackage

`default_nettype wire

[src/rgb_to_hsv_convert.sv]
// Pipelined RGB to HSV pixel converter with two radix-2 restoring dividers.
// Depends on rgbhsv_pkg for the sector code type.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------
//   input   | in_valid / in_stall         | red, green, blue
//   output  | out_valid / out_stall       | hue, saturation, brightness
//
// One pixel enters every clock while in_stall is low. The stages are a
// max/min stage, a numerator stage, then one quotient bit per stage for both
// divisions. The whole pipeline holds when a valid result is stalled at the
// output, and in_stall is raised only then. Reset clears the valid bits only.
`default_nettype none

module rgb_to_hsv_convert #(
	parameter int COMPONENT_BITS = 8,
	parameter int FRACTION_BITS  = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  [COMPONENT_BITS-1:0] red,
	input  wire  [COMPONENT_BITS-1:0] green,
	input  wire  [COMPONENT_BITS-1:0] blue,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic [FRACTION_BITS-1:0]  hue,
	output logic [FRACTION_BITS-1:0]  saturation,
	output logic [COMPONENT_BITS-1:0] brightness
);
	import rgbhsv_pkg::*;

	localparam int CW = COMPONENT_BITS;
	localparam int FW = FRACTION_BITS;
	// Six times delta needs three bits more than a component.
	localparam int DW = COMPONENT_BITS + 3;

	logic ena;

	// Stage 1: largest and smallest component and the sector.
	logic            vld_s1;
	logic [CW-1:0]   r_s1, g_s1, b_s1, mx_s1, mn_s1;
	sector_t         sec_s1;
	logic [CW-1:0]   mx_c, mn_c;
	sector_t         sec_c;

	// Divider stages: index 0 is loaded with dividend and divisor, each
	// later index has retired one more quotient bit.
	logic [FW:0]     div_vld_s;
	logic [DW-1:0]   h_rem_s  [FW+1];
	logic [DW-1:0]   h_den_s  [FW+1];
	logic [FW-1:0]   h_quo_s  [FW+1];
	logic [CW-1:0]   s_rem_s  [FW+1];
	logic [CW-1:0]   s_den_s  [FW+1];
	logic [FW-1:0]   s_quo_s  [FW+1];
	logic            h_zero_s [FW+1];
	logic            s_zero_s [FW+1];
	logic [CW-1:0]   bri_s    [FW+1];

	logic [CW-1:0]   delta_c;
	logic [DW-1:0]   six_d_c, num_c;

	// The pipeline moves as one unless a finished result is held.
	assign ena      = ~(out_valid & out_stall);
	assign in_stall = ~ena;

	// Largest component picks the sector; the first of red, green, blue wins ties.
	always_comb begin
		mx_c  = red;
		mn_c  = red;
		sec_c = SECTOR_RED;
		if (green > mx_c) begin
			mx_c  = green;
			sec_c = SECTOR_GREEN;
		end
		if (blue > mx_c) begin
			mx_c  = blue;
			sec_c = SECTOR_BLUE;
		end
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk) begin
		if (ena) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sec_s1 <= sec_c;
		end
	end

	// Hue numerator in modular arithmetic; the true value lies in [0, 6*delta).
	always_comb begin
		delta_c = mx_s1 - mn_s1;
		six_d_c = DW'({delta_c, 2'b00}) + DW'({delta_c, 1'b0});
		case (sec_s1)
			SECTOR_RED: begin
				num_c = DW'(g_s1) - DW'(b_s1);
				if (g_s1 < b_s1) num_c = num_c + six_d_c;
			end
			SECTOR_GREEN: begin
				num_c = DW'({delta_c, 1'b0}) + DW'(b_s1) - DW'(r_s1);
			end
			SECTOR_BLUE: begin
				num_c = DW'({delta_c, 2'b00}) + DW'(r_s1) - DW'(g_s1);
			end
			default: begin
				num_c = '0;
			end
		endcase
	end

	// Stage 2: load both dividers. A grey pixel has no hue and a black one
	// no saturation; their dividers run on a zero divisor and are masked.
	always_ff @(posedge clk) begin
		if (ena) begin
			h_rem_s[0]  <= num_c;
			h_den_s[0]  <= six_d_c;
			h_quo_s[0]  <= '0;
			s_rem_s[0]  <= delta_c;
			s_den_s[0]  <= mx_s1;
			s_quo_s[0]  <= '0;
			h_zero_s[0] <= (delta_c == '0);
			s_zero_s[0] <= (mx_s1 == '0);
			bri_s[0]    <= mx_s1;
		end
	end

	// One restoring step per stage for each divider. A full-scale delta
	// yields all ones in the saturation quotient, which is the clamped value.
	for (genvar k = 1; k <= FW; k++) begin : g_div
		logic [DW:0] h_two, h_nxt;
		logic        h_bit;
		logic [CW:0] s_two, s_nxt;
		logic        s_bit;

		assign h_two = {h_rem_s[k-1], 1'b0};
		assign h_bit = (h_two >= {1'b0, h_den_s[k-1]});
		assign h_nxt = h_bit ? (h_two - {1'b0, h_den_s[k-1]}) : h_two;
		assign s_two = {s_rem_s[k-1], 1'b0};
		assign s_bit = (s_two >= {1'b0, s_den_s[k-1]});
		assign s_nxt = s_bit ? (s_two - {1'b0, s_den_s[k-1]}) : s_two;

		always_ff @(posedge clk) begin
			if (ena) begin
				h_rem_s[k]  <= h_nxt[DW-1:0];
				h_den_s[k]  <= h_den_s[k-1];
				h_quo_s[k]  <= {h_quo_s[k-1][FW-2:0], h_bit};
				s_rem_s[k]  <= s_nxt[CW-1:0];
				s_den_s[k]  <= s_den_s[k-1];
				s_quo_s[k]  <= {s_quo_s[k-1][FW-2:0], s_bit};
				h_zero_s[k] <= h_zero_s[k-1];
				s_zero_s[k] <= s_zero_s[k-1];
				bri_s[k]    <= bri_s[k-1];
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			div_vld_s <= '0;
		end else if (ena) begin
			vld_s1    <= in_valid;
			div_vld_s <= {div_vld_s[FW-1:0], vld_s1};
		end
	end

	// Result of the last stage.
	assign out_valid  = div_vld_s[FW];
	assign hue        = h_zero_s[FW] ? '0 : h_quo_s[FW];
	assign saturation = s_zero_s[FW] ? '0 : s_quo_s[FW];
	assign brightness = bri_s[FW];

endmodule

`default_nettype wire

[src/rgbhsv_check.sv]
// Port-level checks for the RGB to HSV pixel converter, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module rgbhsv_check #(
	parameter int COMPONENT_BITS = 8,
	parameter int FRACTION_BITS  = 16
) (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_stall,
	input wire [COMPONENT_BITS-1:0] red,
	input wire [COMPONENT_BITS-1:0] green,
	input wire [COMPONENT_BITS-1:0] blue,
	input wire                      out_valid,
	input wire                      out_stall,
	input wire [FRACTION_BITS-1:0]  hue,
	input wire [FRACTION_BITS-1:0]  saturation,
	input wire [COMPONENT_BITS-1:0] brightness
);

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("result payload changed while stalled");

	// The input is held back only while a finished result waits.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without an output stall");

	// A black pixel has neither hue nor saturation.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> hue == '0 && saturation == '0)
		else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_convert rgbhsv_check #(
	.COMPONENT_BITS(COMPONENT_BITS),
	.FRACTION_BITS (FRACTION_BITS)
) u_rgbhsv_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hue       (hue),
	.saturation(saturation),
	.brightness(brightness)
);

`default_nettype wire
